// ===== rtl/ihc_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ihc_pkg: shared types and constants of the IPv4 header receive checker
// Beat types of both channels, the parsed-header record that crosses the
// queue, verdict codes and protocol numbers.
// ============================================================================
package ihc_pkg;

  // Header byte positions
  localparam logic [4:0] POS_IDLE    = 5'd20;
  localparam logic [4:0] POS_LAST    = 5'd19;
  localparam logic [4:0] POS_B0      = 5'd0;
  localparam logic [4:0] POS_TLEN_HI = 5'd2;
  localparam logic [4:0] POS_TLEN_LO = 5'd3;
  localparam logic [4:0] POS_FF_HI   = 5'd6;
  localparam logic [4:0] POS_FF_LO   = 5'd7;
  localparam logic [4:0] POS_TTL     = 5'd8;
  localparam logic [4:0] POS_PROTO   = 5'd9;
  localparam logic [4:0] POS_CSUM_LO = 5'd11;
  localparam logic [4:0] POS_FIRST_W = 5'd1;

  localparam logic [3:0] IP_VERSION_4 = 4'd4;

  // Verdict codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_CHECKSUM = 3'd1;
  localparam logic [2:0] ERR_VERSION  = 3'd2;
  localparam logic [2:0] ERR_TTL_ZERO = 3'd3;
  localparam logic [2:0] ERR_LEN_ZERO = 3'd4;

  // Protocol numbers and classes
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [1:0] CLS_ICMP  = 2'd0;
  localparam logic [1:0] CLS_TCP   = 2'd1;
  localparam logic [1:0] CLS_UDP   = 2'd2;
  localparam logic [1:0] CLS_OTHER = 2'd3;

  // Depth of the record queue between parser and verdict stage
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } ihc_in_t;

  typedef struct packed {
    logic        accept;
    logic [2:0]  error_code;
    logic [1:0]  protocol_class;
    logic [7:0]  protocol_number;
    logic [3:0]  header_words;
    logic [15:0] total_length;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [2:0]  flag_bits;
    logic [12:0] fragment_offset;
  } ihc_out_t;

  // One parsed header, ready for judging
  typedef struct packed {
    logic [15:0] sum;
    logic [15:0] rx_csum;
    logic [7:0]  b0;
    logic [15:0] tlen;
    logic [15:0] ff;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
  } ihc_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ihc_q_stat_t;

endpackage

// ===== rtl/ihc_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ihc_front: header byte parser
// Tracks the byte position, captures fields and keeps the running
// one's-complement word sum; pushes one record with the last header byte.
// ============================================================================
module ihc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 hdr_valid,
  output logic                 hdr_stall,
  input  ihc_pkg::ihc_in_t     hdr,
  input  ihc_pkg::ihc_q_stat_t q_stat,
  output logic                 push,
  output ihc_pkg::ihc_rec_t    rec_out
);
  import ihc_pkg::*;

  logic [4:0]  pos;
  logic [4:0]  pos_next;
  logic [4:0]  cur_pos;
  logic        take;
  logic        work;
  logic [7:0]  hold;
  logic [15:0] word;
  logic [16:0] raw_sum;
  logic [15:0] sum_new;
  logic [1:0]  lane;
  ihc_rec_t    rec;

  assign hdr_stall = q_stat.full;
  assign take      = hdr_valid & ~q_stat.full;
  assign cur_pos   = hdr.start_req ? POS_B0 : pos;
  assign work      = take & (hdr.start_req | (pos < POS_IDLE));
  assign word      = {hold, hdr.data_byte};
  assign lane      = ~cur_pos[1:0];

  // end-around carry add; the first word of a header starts from zero
  always_comb begin
    raw_sum = {1'b0, rec.sum} + {1'b0, word};
    if (cur_pos == POS_FIRST_W) begin
      sum_new = word;
    end else begin
      sum_new = raw_sum[15:0] + {15'd0, raw_sum[16]};
    end
  end

  always_comb begin
    pos_next = pos;
    if (work) begin
      pos_next = (cur_pos == POS_LAST) ? POS_IDLE : cur_pos + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_IDLE;
    end else begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      if (!cur_pos[0]) begin
        hold <= hdr.data_byte;
      end else if (cur_pos == POS_CSUM_LO) begin
        rec.rx_csum <= word;
      end else begin
        rec.sum <= sum_new;
      end
      case (cur_pos)
        POS_B0:      rec.b0         <= hdr.data_byte;
        POS_TLEN_HI: rec.tlen[15:8] <= hdr.data_byte;
        POS_TLEN_LO: rec.tlen[7:0]  <= hdr.data_byte;
        POS_FF_HI:   rec.ff[15:8]   <= hdr.data_byte;
        POS_FF_LO:   rec.ff[7:0]    <= hdr.data_byte;
        POS_TTL:     rec.ttl        <= hdr.data_byte;
        POS_PROTO:   rec.proto      <= hdr.data_byte;
        default: begin
          if (cur_pos >= 5'd16) begin
            rec.dst[{lane, 3'b000} +: 8] <= hdr.data_byte;
          end else if (cur_pos >= 5'd12) begin
            rec.src[{lane, 3'b000} +: 8] <= hdr.data_byte;
          end
        end
      endcase
    end
  end

  // the last beat completes the sum and the destination address on the fly
  assign push = work & (cur_pos == POS_LAST);

  always_comb begin
    rec_out          = rec;
    rec_out.sum      = sum_new;
    rec_out.dst[7:0] = hdr.data_byte;
  end

endmodule

// ===== rtl/ihc_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ihc_queue: record queue
// Small register queue that decouples the parser from the verdict stage.
// ============================================================================
module ihc_queue #(
  parameter int Depth = ihc_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ihc_pkg::ihc_rec_t    wr_rec,
  input  logic                 pop,
  output ihc_pkg::ihc_rec_t    head,
  output ihc_pkg::ihc_q_stat_t stat
);
  import ihc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ihc_rec_t            slots [Depth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     cnt;
  logic [CntW-1:0]     cnt_next;

  assign head       = slots[rd_ptr];
  assign stat.full  = (cnt == CntW'(Depth));
  assign stat.empty = (cnt == '0);

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) begin
      cnt_next = cnt + 1'b1;
    end else if (pop && !push) begin
      cnt_next = cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      cnt <= cnt_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_rec;
    end
  end

endmodule

// ===== rtl/ihc_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ihc_back: verdict stage
// Judges the record at the queue head and holds the verdict in the output
// register until it is taken.
// ============================================================================
module ihc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  ihc_pkg::ihc_rec_t    head,
  input  ihc_pkg::ihc_q_stat_t q_stat,
  output logic                 pop,
  output logic                 verdict_valid,
  input  logic                 verdict_stall,
  output ihc_pkg::ihc_out_t    verdict
);
  import ihc_pkg::*;

  ihc_out_t   judged;
  logic [2:0] err;
  logic [1:0] cls;
  logic       load;

  always_comb begin
    if (~head.sum != head.rx_csum) begin
      err = ERR_CHECKSUM;
    end else if (head.b0[7:4] != IP_VERSION_4) begin
      err = ERR_VERSION;
    end else if (head.ttl == 8'd0) begin
      err = ERR_TTL_ZERO;
    end else if (head.tlen == 16'd0) begin
      err = ERR_LEN_ZERO;
    end else begin
      err = ERR_NONE;
    end
  end

  always_comb begin
    unique case (head.proto)
      PROTO_ICMP: cls = CLS_ICMP;
      PROTO_TCP:  cls = CLS_TCP;
      PROTO_UDP:  cls = CLS_UDP;
      default:    cls = CLS_OTHER;
    endcase
  end

  always_comb begin
    judged.accept              = (err == ERR_NONE);
    judged.error_code          = err;
    judged.protocol_class      = cls;
    judged.protocol_number     = head.proto;
    judged.header_words        = head.b0[3:0];
    judged.total_length        = head.tlen;
    judged.source_address      = head.src;
    judged.destination_address = head.dst;
    judged.flag_bits           = head.ff[15:13];
    judged.fragment_offset     = head.ff[12:0];
  end

  assign load = ~verdict_valid | ~verdict_stall;
  assign pop  = load & ~q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (load) begin
      verdict_valid <= ~q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      verdict <= judged;
    end
  end

endmodule

// ===== rtl/ipv4_header_rx_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ipv4_header_rx_checker: IPv4 header receive checker
// Parses a 20-byte IPv4 header one byte per beat, checks its one's-complement
// checksum, version, TTL and total length, and reports one verdict beat.
// ============================================================================
// Verdict path: the header record enters the queue on the edge that takes header
//   byte 19, and the verdict register loads from the queue head when it is free.
// Throughput: one header byte per cycle unless stalled; headers go back to back.
// The parser stalls only while the record queue is full, which happens when
//   the verdict output has been stalled long enough to back it up.
// Reset (rst, synchronous, active high): parser idles until a start beat,
//   record queue empties, no verdict is offered.
module ipv4_header_rx_checker #(
  parameter int QueueDepth = ihc_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  // header byte beats
  input  logic              hdr_valid,
  output logic              hdr_stall,
  input  ihc_pkg::ihc_in_t  hdr,
  // verdict beats
  output logic              verdict_valid,
  input  logic              verdict_stall,
  output ihc_pkg::ihc_out_t verdict
);
  import ihc_pkg::*;

  // Front end: byte position counter, field capture and running checksum.
  // A start beat restarts the parse at once; bytes outside a header drop.
  ihc_q_stat_t q_stat;
  ihc_rec_t    push_rec;
  ihc_rec_t    head_rec;
  logic        push;
  logic        pop;

  ihc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .hdr_valid (hdr_valid),
    .hdr_stall (hdr_stall),
    .hdr       (hdr),
    .q_stat    (q_stat),
    .push      (push),
    .rec_out   (push_rec)
  );

  // Record queue: one entry per completed header, so a stalled verdict
  // output does not hold up the incoming byte stream.
  ihc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (push_rec),
    .pop    (pop),
    .head   (head_rec),
    .stat   (q_stat)
  );

  // Back end: priority checks (checksum, version, TTL, length), protocol
  // class, and the registered verdict beat.
  ihc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head_rec),
    .q_stat        (q_stat),
    .pop           (pop),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall),
    .verdict       (verdict)
  );

endmodule

// ===== rtl/ihc_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ihc_checker: port-level assertions for the header checker
// Watches the top-level ports only; attached by bind.
// ============================================================================
module ihc_checker (
  input logic              clk,
  input logic              rst,
  input logic              hdr_valid,
  input logic              hdr_stall,
  input ihc_pkg::ihc_in_t  hdr,
  input logic              verdict_valid,
  input logic              verdict_stall,
  input ihc_pkg::ihc_out_t verdict
);
  import ihc_pkg::*;

  // a stalled verdict beat holds
  a_verdict_hold: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && verdict_stall |=> verdict_valid && $stable(verdict))
    else $error("verdict beat changed while stalled");

  // accept flag agrees with the error code
  a_accept_code: assert property (@(posedge clk) disable iff (rst)
    verdict_valid |-> (verdict.accept == (verdict.error_code == ERR_NONE)))
    else $error("accept flag disagrees with error code");

  // TCP protocol class follows the raw protocol number
  a_class_tcp: assert property (@(posedge clk) disable iff (rst)
    verdict_valid |->
      ((verdict.protocol_class == CLS_TCP) == (verdict.protocol_number == PROTO_TCP)))
    else $error("protocol class mismatch");

  // no verdict right out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !verdict_valid)
    else $error("verdict offered after reset");

endmodule

bind ipv4_header_rx_checker ihc_checker u_ihc_checker (.*);
